// File: design/cer_pkg.sv
// Shared types and codes of the coalescing event ring.
`default_nettype none

package cer_pkg;

    typedef struct packed {
        logic [30:0] code;
        logic [63:0] arg_one;
        logic [63:0] arg_two;
        logic [63:0] post_time;
        logic [63:0] repeat_word;
        logic [15:0] sender;
        logic [15:0] receiver;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    localparam logic [2:0] ST_POSTED    = 3'd0;
    localparam logic [2:0] ST_COALESCED = 3'd1;
    localparam logic [2:0] ST_REJECTED  = 3'd2;
    localparam logic [2:0] ST_DELIVERED = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    localparam logic [2:0] REG_BLOCK_ON_EMPTY  = 3'd0;
    localparam logic [2:0] REG_CODE_MOUSE_MOVE = 3'd1;
    localparam logic [2:0] REG_CODE_KEY_DOWN   = 3'd2;
    localparam logic [2:0] REG_CODE_ARROW_UP   = 3'd3;
    localparam logic [2:0] REG_CODE_ARROW_DOWN = 3'd4;
    localparam logic [2:0] REG_CODE_ARROW_LEFT = 3'd5;
    localparam logic [2:0] REG_CODE_ARROW_RIGHT = 3'd6;

    localparam logic KIND_POST = 1'b0;
    localparam logic KIND_GET  = 1'b1;

    localparam logic [15:0] MISS_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// File: design/cer_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module cer_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/coalescing_event_ring.sv
// Top level of the coalescing event ring: slot memory, pointers, merge logic and result register.
`default_nettype none

// A ring of QUEUE_DEPTH message slots. A post (kind 0) with a positive code either writes
// the tail slot or merges into the newest slot (mouse move, repeated key down, repeated
// control arrow); other posts are rejected. A get (kind 1) delivers and clears the head
// slot, or reports it empty. Every beat gives one result beat. The block takes one beat per
// cycle while in_stall is low; the registered read of the slot memory is loaded at the same
// edge as the input beat, and the merge logic fills the result register once the output is
// ready. The longest path runs from the memory read data through the newest-slot compare and
// the tail pointer to the next read address. After reset a clearing pass writes every slot,
// during which in_stall is high; configuration writes are taken throughout.
module coalescing_event_ring #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [30:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic signed [31:0] msg_code,
    input  wire logic [63:0]        arg_one,
    input  wire logic [63:0]        arg_two,
    input  wire logic [15:0]        sender_id,
    input  wire logic [15:0]        receiver_id,
    input  wire logic [63:0]        now_ticks,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              status,
    output logic [30:0]             out_code,
    output logic [63:0]             out_arg_one,
    output logic [63:0]             out_arg_two,
    output logic [63:0]             out_post_time,
    output logic [63:0]             out_repeat_word,
    output logic [15:0]             out_sender,
    output logic [15:0]             out_receiver,
    output logic                    block_pending
);

    import cer_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [15:0] MISS_LIMIT = 16'(QUEUE_DEPTH + 4);

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == LAST_IDX) ? '0 : i + 1'b1;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == '0) ? LAST_IDX : i - 1'b1;
        return r;
    endfunction

    // Configuration registers.
    logic        block_on_empty_reg;
    logic [30:0] code_mouse_reg;
    logic [30:0] code_key_reg;
    logic [30:0] code_up_reg;
    logic [30:0] code_down_reg;
    logic [30:0] code_left_reg;
    logic [30:0] code_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_on_empty_reg <= 1'b0;
            code_mouse_reg     <= '0;
            code_key_reg       <= '0;
            code_up_reg        <= '0;
            code_down_reg      <= '0;
            code_left_reg      <= '0;
            code_right_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BLOCK_ON_EMPTY:   block_on_empty_reg <= cfg_data[0];
                REG_CODE_MOUSE_MOVE:  code_mouse_reg     <= cfg_data;
                REG_CODE_KEY_DOWN:    code_key_reg       <= cfg_data;
                REG_CODE_ARROW_UP:    code_up_reg        <= cfg_data;
                REG_CODE_ARROW_DOWN:  code_down_reg      <= cfg_data;
                REG_CODE_ARROW_LEFT:  code_left_reg      <= cfg_data;
                REG_CODE_ARROW_RIGHT: code_right_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Control state.
    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [15:0]      miss_reg, miss_next;
    logic             block_flag_reg, block_flag_next;
    logic             s1_valid_reg;
    logic             out_valid_reg;
    logic             fwd_hit_reg;

    // Stage one payload.
    logic               s1_kind_reg;
    logic signed [31:0] s1_code_reg;
    logic [63:0]        s1_arg_one_reg;
    logic [63:0]        s1_arg_two_reg;
    logic [15:0]        s1_sender_reg;
    logic [15:0]        s1_receiver_reg;
    logic [63:0]        s1_now_reg;
    logic [IDX_W-1:0]   s1_addr_reg;
    slot_t              fwd_data_reg;

    // Result payload.
    logic [2:0] status_reg;
    slot_t      res_slot_reg;
    logic       block_pending_reg;

    logic             out_ready;
    logic             retire;
    logic             accept;
    logic [IDX_W-1:0] rd_addr;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    slot_t            ram_wr_data;
    logic [SLOT_W-1:0] ram_rd_data;
    slot_t            cur_slot;
    slot_t            merged_slot;
    slot_t            fresh_slot;
    slot_t            res_slot_next;
    logic [2:0]       status_next;
    logic [30:0]      code31;
    logic             post_ok;
    logic             same_rcv;
    logic             is_arrow;
    logic             hit_mouse;
    logic             hit_key;
    logic             hit_arrow;
    logic             merge;
    logic             slot_empty;
    logic [15:0]      miss_inc;

    assign out_ready = !out_valid_reg || !out_stall;
    assign retire    = s1_valid_reg && out_ready;
    assign in_stall  = clr_active_reg || (s1_valid_reg && !out_ready);
    assign accept    = in_valid && !in_stall;

    cer_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        cur_slot = fwd_hit_reg ? fwd_data_reg : slot_t'(ram_rd_data);
        code31   = s1_code_reg[30:0];
        post_ok  = s1_code_reg > 32'sd0;
        same_rcv = cur_slot.receiver == s1_receiver_reg;
        is_arrow = code31 == code_up_reg || code31 == code_down_reg ||
                   code31 == code_left_reg || code31 == code_right_reg;
        hit_mouse = code31 == code_mouse_reg && cur_slot.code == code_mouse_reg && same_rcv;
        hit_key   = code31 == code_key_reg && same_rcv && cur_slot.code == code_key_reg &&
                    cur_slot.arg_one == s1_arg_one_reg;
        hit_arrow = is_arrow && same_rcv && cur_slot.code == code31;
        merge     = hit_mouse || hit_key || hit_arrow;
        slot_empty = cur_slot.code == '0;

        merged_slot = cur_slot;
        merged_slot.sender   = s1_sender_reg;
        merged_slot.receiver = s1_receiver_reg;
        merged_slot.post_time = s1_now_reg;
        if (hit_mouse)
        begin
            merged_slot.arg_one     = s1_arg_one_reg;
            merged_slot.arg_two     = s1_arg_two_reg;
            merged_slot.repeat_word = s1_now_reg;
        end
        else if (hit_key)
        begin
            merged_slot.arg_one     = s1_arg_one_reg;
            merged_slot.arg_two     = s1_arg_two_reg;
            merged_slot.repeat_word = cur_slot.repeat_word + 64'd1;
        end
        else
        begin
            merged_slot.repeat_word = cur_slot.repeat_word + 64'd1;
        end

        fresh_slot.code        = code31;
        fresh_slot.arg_one     = s1_arg_one_reg;
        fresh_slot.arg_two     = s1_arg_two_reg;
        fresh_slot.post_time   = s1_now_reg;
        fresh_slot.repeat_word = s1_now_reg;
        fresh_slot.sender      = s1_sender_reg;
        fresh_slot.receiver    = s1_receiver_reg;

        head_next       = head_reg;
        tail_next       = tail_reg;
        miss_next       = miss_reg;
        miss_inc        = miss_reg;
        block_flag_next = block_flag_reg;
        res_slot_next   = '0;
        status_next     = ST_REJECTED;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = s1_addr_reg;
        ram_wr_data     = '0;

        if (s1_kind_reg == KIND_POST)
        begin
            if (post_ok)
            begin
                ram_wr_en = retire;
                if (merge)
                begin
                    status_next = ST_COALESCED;
                    ram_wr_data = merged_slot;
                end
                else
                begin
                    status_next = ST_POSTED;
                    ram_wr_addr = tail_reg;
                    ram_wr_data = fresh_slot;
                    if (retire)
                    begin
                        tail_next = idx_inc(tail_reg);
                    end
                end
            end
        end
        else
        begin
            ram_wr_en = retire;
            if (retire)
            begin
                head_next = idx_inc(head_reg);
            end
            if (!slot_empty)
            begin
                status_next   = ST_DELIVERED;
                res_slot_next = cur_slot;
            end
            else
            begin
                status_next = ST_EMPTY;
                miss_inc = (miss_reg < MISS_MAX) ? miss_reg + 16'd1 : miss_reg;
                if (block_on_empty_reg && miss_inc > MISS_LIMIT)
                begin
                    miss_inc = '0;
                    if (retire)
                    begin
                        block_flag_next = 1'b1;
                    end
                end
                if (retire)
                begin
                    miss_next = miss_inc;
                end
            end
        end

        if (clr_active_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_reg;
            ram_wr_data = '0;
        end

        rd_addr = (kind == KIND_GET) ? head_next : idx_dec(tail_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            miss_reg       <= '0;
            block_flag_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_idx_reg <= idx_inc(clr_idx_reg);
                if (clr_idx_reg == LAST_IDX)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            miss_reg       <= miss_next;
            block_flag_reg <= block_flag_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= ram_wr_en && (ram_wr_addr == rd_addr);
            end
            else if (retire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_ready)
            begin
                out_valid_reg <= retire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg     <= kind;
            s1_code_reg     <= msg_code;
            s1_arg_one_reg  <= arg_one;
            s1_arg_two_reg  <= arg_two;
            s1_sender_reg   <= sender_id;
            s1_receiver_reg <= receiver_id;
            s1_now_reg      <= now_ticks;
            s1_addr_reg     <= rd_addr;
            fwd_data_reg    <= ram_wr_data;
        end
        if (retire)
        begin
            status_reg        <= status_next;
            res_slot_reg      <= res_slot_next;
            block_pending_reg <= block_flag_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign out_code        = res_slot_reg.code;
    assign out_arg_one     = res_slot_reg.arg_one;
    assign out_arg_two     = res_slot_reg.arg_two;
    assign out_post_time   = res_slot_reg.post_time;
    assign out_repeat_word = res_slot_reg.repeat_word;
    assign out_sender      = res_slot_reg.sender;
    assign out_receiver    = res_slot_reg.receiver;
    assign block_pending   = block_pending_reg;

`ifndef SYNTHESIS
    property p_no_beat_while_clearing;
        @(posedge clk) disable iff (!rst_n) clr_active_reg |-> in_stall;
    endproperty
    a_no_beat_while_clearing: assert property (p_no_beat_while_clearing)
        else $error("input beat taken during the clearing pass");

    property p_block_sticky;
        @(posedge clk) disable iff (!rst_n) block_flag_reg |=> block_flag_reg;
    endproperty
    a_block_sticky: assert property (p_block_sticky)
        else $error("block flag dropped without reset");

    property p_delivered_has_code;
        @(posedge clk) disable iff (!rst_n)
            (out_valid_reg && status_reg == ST_DELIVERED) |-> (res_slot_reg.code != '0);
    endproperty
    a_delivered_has_code: assert property (p_delivered_has_code)
        else $error("delivered beat carries an empty slot");

    property p_fwd_only_in_flight;
        @(posedge clk) disable iff (!rst_n) fwd_hit_reg |-> s1_valid_reg || !clr_active_reg;
    endproperty
    a_fwd_only_in_flight: assert property (p_fwd_only_in_flight)
        else $error("bypass marked during the clearing pass");
`endif

endmodule

`default_nettype wire
